/* design/rcph_pkg.sv */
// Package with the shared constants, widths and state type of the ray and polyhedron hit core.
`default_nettype none
package rcph_pkg;
  localparam int MaxPlanesDefault = 32;
  localparam logic [31:0] ParallelLimitReset = 32'd4295;
  localparam int NormalW = 18;
  localparam int NormalPackW = 3 * NormalW;
  localparam int CoordW = 32;
  localparam int ProdW = NormalW + CoordW;     // one normal by coordinate product
  localparam int FacingW = ProdW + 1;          // sum of three products
  localparam int InsideW = ProdW + 3;          // offset term minus the dot product
  localparam int MagW = InsideW - 1;
  localparam int NumW = 68;                    // dividend bits walked by the divider
  localparam int QuotW = 41;
  localparam int DivCntW = 7;

  localparam logic [0:0] OpWrite = 1'b0;
  localparam logic [0:0] OpCast  = 1'b1;

  localparam logic [0:0] RegActivePlanes  = 1'b0;
  localparam logic [0:0] RegParallelLimit = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;
endpackage
`default_nettype wire

/* design/rcph_ram.sv */
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module rcph_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* design/ray_convex_polyhedron_hit_core.sv */
// Top level: convex solid plane table and the plane by plane ray clipping sequencer.
// A plane write word gives no result and leaves the sequencer idle.
// A cast word walks each active plane through read, multiply, sum and check, then through the
// one-bit-per-cycle restoring divider and update, while a parallel plane stops after check.
// One word is worked on at a time, so no new word is taken until the cast is finished; a
// result not yet taken holds the sequencer. Synchronous active-high reset clears the
// sequencer, the output valid and the configuration registers; the plane memories are not
// cleared and hold nothing until written.
`default_nettype none
module ray_convex_polyhedron_hit_core #(
  parameter int MaxPlanes = rcph_pkg::MaxPlanesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [0:0]          operation,
  input  wire logic [4:0]          entry_index,
  input  wire logic signed [17:0]  normal_x,
  input  wire logic signed [17:0]  normal_y,
  input  wire logic signed [17:0]  normal_z,
  input  wire logic signed [31:0]  plane_offset,
  input  wire logic signed [31:0]  start_x,
  input  wire logic signed [31:0]  start_y,
  input  wire logic signed [31:0]  start_z,
  input  wire logic signed [31:0]  heading_x,
  input  wire logic signed [31:0]  heading_y,
  input  wire logic signed [31:0]  heading_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     hit,
  output logic signed [31:0]       hit_distance,
  output logic [4:0]               hit_plane
);
  import rcph_pkg::*;

  localparam int AddrW = $clog2(MaxPlanes);
  localparam int CountW = AddrW + 1;

  // Configuration registers.
  logic [5:0]  active_planes;
  logic [31:0] parallel_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_planes  <= '0;
      parallel_limit <= ParallelLimitReset;
    end else if (cfg_write_en) begin
      case (cfg_index)
        RegActivePlanes:  active_planes  <= cfg_data[5:0];
        RegParallelLimit: parallel_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic in_take;
  assign in_take = in_valid && in_ready;

  // Plane memories: the normal triple packed x low, and the offset.
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [AddrW-1:0]      rd_addr;
  logic [NormalPackW-1:0] normal_rd;
  logic [CoordW-1:0]     offset_rd;

  // A write beyond the table is dropped.
  assign wr_en   = in_take && (operation == OpWrite) && (9'(entry_index) < 9'(MaxPlanes));
  assign wr_addr = AddrW'(entry_index);

  rcph_ram #(.Width(NormalPackW), .Depth(MaxPlanes)) u_normal_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({normal_z, normal_y, normal_x}),
    .rd_addr (rd_addr),
    .rd_data (normal_rd)
  );

  rcph_ram #(.Width(CoordW), .Depth(MaxPlanes)) u_offset_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (plane_offset),
    .rd_addr (rd_addr),
    .rd_data (offset_rd)
  );

  // Ray held for the whole cast.
  logic signed [31:0] sx, sy, sz, hx, hy, hz;
  logic [CountW-1:0]  plane_cnt;
  logic [CountW-1:0]  plane_idx;
  assign rd_addr = plane_idx[AddrW-1:0];

  // Per-plane arithmetic registers.
  logic signed [ProdW-1:0]   pfx, pfy, pfz, psx, psy, psz;
  logic signed [CoordW-1:0]  off_q;
  logic signed [FacingW-1:0] facing;
  logic signed [InsideW-1:0] margin;

  // Divider state.
  logic [NumW-1:0]    num;
  logic [FacingW-1:0] den;
  logic [FacingW-1:0] rem;
  logic [QuotW-1:0]   quo;
  logic               big;
  logic               quo_neg;
  logic [DivCntW-1:0] div_cnt;

  // Running entry and exit.
  logic signed [31:0] enter, leave;
  logic [AddrW-1:0]   entry_plane;
  logic               have_enter, have_exit, missed;

  logic [FacingW-1:0] facing_mag;
  logic [MagW-1:0]    margin_mag;
  logic               parallel;
  assign facing_mag = facing[FacingW-1] ? FacingW'(-facing) : FacingW'(facing);
  assign margin_mag = margin[InsideW-1] ? MagW'(-margin) : MagW'(margin);
  assign parallel   = (facing == '0) ||
                      (facing_mag < FacingW'(parallel_limit));

  // One restoring step: bring down the next dividend bit and try the subtraction.
  logic [FacingW:0] rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem, num[NumW-1]};
  assign rem_ge = rem_sh >= {1'b0, den};

  // Saturate the quotient to a signed 32-bit distance.
  logic signed [31:0] plane_dist;
  always_comb begin
    if (quo_neg) begin
      if (big || quo > QuotW'(33'h0_8000_0000)) begin
        plane_dist = 32'sh8000_0000;
      end else begin
        plane_dist = 32'(-quo);
      end
    end else if (big || quo > QuotW'(32'h7FFF_FFFF)) begin
      plane_dist = 32'sh7FFF_FFFF;
    end else begin
      plane_dist = 32'(quo);
    end
  end

  logic last_plane;
  assign last_plane = (plane_idx + CountW'(1)) == plane_cnt;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_take && operation == OpCast) begin
        state_next = (active_planes == '0) ? ST_FINISH : ST_READ;
      end
      ST_READ:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_CHECK;
      ST_CHECK:  begin
        if (parallel) begin
          if (margin[InsideW-1] || last_plane) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_READ;
          end
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:    if (div_cnt == '0) begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = last_plane ? ST_FINISH : ST_READ;
      ST_FINISH: if (out_free) begin
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          sx <= start_x;   sy <= start_y;   sz <= start_z;
          hx <= heading_x; hy <= heading_y; hz <= heading_z;
          plane_cnt  <= (9'(active_planes) > 9'(MaxPlanes)) ? CountW'(MaxPlanes)
                                                            : CountW'(active_planes);
          plane_idx  <= '0;
          have_enter <= 1'b0;
          have_exit  <= 1'b0;
          missed     <= 1'b0;
          enter      <= '0;
          leave      <= '0;
          entry_plane <= '0;
        end
      end
      ST_MUL: begin
        pfx <= $signed(normal_rd[17:0])  * hx;
        pfy <= $signed(normal_rd[35:18]) * hy;
        pfz <= $signed(normal_rd[53:36]) * hz;
        psx <= $signed(normal_rd[17:0])  * sx;
        psy <= $signed(normal_rd[35:18]) * sy;
        psz <= $signed(normal_rd[53:36]) * sz;
        off_q <= offset_rd;
      end
      ST_SUM: begin
        facing <= FacingW'(pfx) + FacingW'(pfy) + FacingW'(pfz);
        margin <= InsideW'($signed({off_q, 16'h0000})) -
                  (InsideW'(psx) + InsideW'(psy) + InsideW'(psz));
      end
      ST_CHECK: begin
        if (parallel) begin
          if (margin[InsideW-1]) begin
            missed <= 1'b1;
          end else begin
            plane_idx <= plane_idx + CountW'(1);
          end
        end else begin
          num     <= NumW'({margin_mag, 16'h0000});
          den     <= facing_mag;
          rem     <= '0;
          quo     <= '0;
          big     <= 1'b0;
          quo_neg <= margin[InsideW-1] != facing[FacingW-1];
          div_cnt <= DivCntW'(NumW - 1);
        end
      end
      ST_DIV: begin
        num     <= num << 1;
        div_cnt <= div_cnt - DivCntW'(1);
        if (quo[QuotW-1]) begin
          big <= 1'b1;
        end
        if (rem_ge) begin
          rem <= FacingW'(rem_sh - {1'b0, den});
          quo <= {quo[QuotW-2:0], 1'b1};
        end else begin
          rem <= FacingW'(rem_sh);
          quo <= {quo[QuotW-2:0], 1'b0};
        end
      end
      ST_UPDATE: begin
        if (facing[FacingW-1]) begin
          if (!have_enter || plane_dist > enter) begin
            enter       <= plane_dist;
            entry_plane <= plane_idx[AddrW-1:0];
            have_enter  <= 1'b1;
          end
        end else if (!have_exit || plane_dist < leave) begin
          leave     <= plane_dist;
          have_exit <= 1'b1;
        end
        plane_idx <= plane_idx + CountW'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          if (missed || !have_enter || enter < 0 || (have_exit && enter > leave)) begin
            hit          <= 1'b0;
            hit_distance <= '0;
            hit_plane    <= '0;
          end else begin
            hit          <= 1'b1;
            hit_distance <= enter;
            hit_plane    <= 5'(entry_plane);
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/rcph_checker.sv */
// Port-level checker for the hit core, bound to the top level.
`default_nettype none
module rcph_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               hit,
  input wire logic signed [31:0] hit_distance,
  input wire logic [4:0]         hit_plane
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_distance) && $stable(hit_plane))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == 0 && hit_plane == 0)
    else $error("miss carries a distance or plane");

  a_hit_ahead: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !hit_distance[31])
    else $error("hit with negative distance");
endmodule

bind ray_convex_polyhedron_hit_core rcph_checker u_rcph_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hit          (hit),
  .hit_distance (hit_distance),
  .hit_plane    (hit_plane)
);
`default_nettype wire

/* tb/sv/tb_ray_convex_polyhedron_hit_core.sv */
// Self-checking testbench for the ray and convex polyhedron hit core, with directed and random words.
`default_nettype none
module tb_ray_convex_polyhedron_hit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rcph_pkg::*;

  // One Q16.16 unit, and a watchdog limit above the slowest gap between accepted words that a
  // correct block can show: a full-table cast behind the longest receiver hold-off.
  localparam int One = 65536;
  localparam int QuietLimit = 20000;
  localparam int HoldOffCycles = 3000;
  localparam int TablePlanes = 32;

  typedef struct packed {
    logic [0:0]         op;
    logic [4:0]         idx;
    logic signed [17:0] nx, ny, nz;
    logic signed [31:0] off;
    logic signed [31:0] sx, sy, sz;
    logic signed [31:0] hx, hy, hz;
  } word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic [4:0]         plane;
  } outcome_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [0:0] reg_idx;
    logic [31:0] reg_val;
    word_t      w;
    bit         typed;
    outcome_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [0:0] cfg_index = RegActivePlanes;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] operation = OpWrite;
  logic [4:0] entry_index = '0;
  logic signed [17:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [31:0] plane_offset = '0;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] heading_x = '0, heading_y = '0, heading_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [31:0] hit_distance;
  logic [4:0] hit_plane;

  ray_convex_polyhedron_hit_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .entry_index(entry_index),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .heading_x(heading_x), .heading_y(heading_y), .heading_z(heading_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_distance(hit_distance), .hit_plane(hit_plane)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Our own copy of the plane table and of the two configuration registers.
  logic signed [17:0] tbl_nx [TablePlanes];
  logic signed [17:0] tbl_ny [TablePlanes];
  logic signed [17:0] tbl_nz [TablePlanes];
  logic signed [31:0] tbl_off [TablePlanes];
  logic [5:0] active_count = 6'd0;
  logic [31:0] parallel_floor = ParallelLimitReset;

  outcome_t pending_outcomes [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // (margin * 2^16) / facing on magnitudes, truncated towards zero and saturated to 32 bits.
  // 128-bit arithmetic holds the full quotient, so saturation is a plain range check.
  function automatic logic signed [31:0] entry_quotient(input longint margin,
                                                        input longint facing);
    logic [127:0] num, den, q;
    bit neg;
    num = {64'd0, magnitude(margin)} << 16;
    den = {64'd0, magnitude(facing)};
    q = num / den;
    neg = (margin < 0) != (facing < 0);
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return $signed(q[31:0]);
  endfunction

  // Clips the ray against each active plane and keeps the latest entry and earliest exit.
  function automatic outcome_t clip_ray(input word_t w);
    outcome_t res;
    int count;
    longint facing, margin;
    logic signed [31:0] quot, enter_d, leave_d;
    bit have_enter, have_exit;
    logic [4:0] enter_p;
    res = '0;
    enter_d = '0;
    leave_d = '0;
    enter_p = '0;
    have_enter = 0;
    have_exit = 0;
    count = (active_count > TablePlanes) ? TablePlanes : int'(active_count);
    for (int i = 0; i < count; i++) begin
      facing = longint'(tbl_nx[i]) * longint'(w.hx) + longint'(tbl_ny[i]) * longint'(w.hy)
             + longint'(tbl_nz[i]) * longint'(w.hz);
      margin = longint'(tbl_off[i]) * 65536
             - (longint'(tbl_nx[i]) * longint'(w.sx) + longint'(tbl_ny[i]) * longint'(w.sy)
              + longint'(tbl_nz[i]) * longint'(w.sz));
      // A facing of exactly zero is parallel whatever the limit says.
      if (facing == 0 || magnitude(facing) < longint'({32'd0, parallel_floor})) begin
        if (margin < 0) return '0;
        continue;
      end
      quot = entry_quotient(margin, facing);
      if (facing < 0) begin
        // Strictly greater, so the lowest plane index keeps a tie.
        if (!have_enter || quot > enter_d) begin
          enter_d = quot;
          enter_p = i[4:0];
          have_enter = 1;
        end
      end else if (!have_exit || quot < leave_d) begin
        leave_d = quot;
        have_exit = 1;
      end
    end
    if (!have_enter || enter_d < 0 || (have_exit && enter_d > leave_d)) return '0;
    res.hit = 1'b1;
    res.distance = enter_d;
    res.plane = enter_p;
    return res;
  endfunction

  function automatic word_t plane_word(input int idx, input int nx, input int ny, input int nz,
                                       input int off);
    word_t w;
    w = '0;
    w.op = OpWrite;
    w.idx = idx[4:0];
    w.nx = nx[17:0];
    w.ny = ny[17:0];
    w.nz = nz[17:0];
    w.off = off;
    return w;
  endfunction

  function automatic word_t ray_word(input int sx, input int sy, input int sz,
                                     input int hx, input int hy, input int hz);
    word_t w;
    w = '0;
    w.op = OpCast;
    w.sx = sx; w.sy = sy; w.sz = sz;
    w.hx = hx; w.hy = hy; w.hz = hz;
    return w;
  endfunction

  // Offers one word, with random idle cycles in front, and books it once accepted.
  task automatic send_word(input word_t w, input bit typed, input outcome_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    operation <= w.op;
    entry_index <= w.idx;
    normal_x <= w.nx;
    normal_y <= w.ny;
    normal_z <= w.nz;
    plane_offset <= w.off;
    start_x <= w.sx;
    start_y <= w.sy;
    start_z <= w.sz;
    heading_x <= w.hx;
    heading_y <= w.hy;
    heading_z <= w.hz;
    do @(posedge clk); while (!in_ready);
    if (w.op == OpCast) begin
      pending_outcomes.push_back(typed ? want : clip_ray(w));
    end else begin
      tbl_nx[w.idx] = w.nx;
      tbl_ny[w.idx] = w.ny;
      tbl_nz[w.idx] = w.nz;
      tbl_off[w.idx] = w.off;
    end
  endtask

  // Registers change only once the block has gone quiet: every result taken, plus a margin.
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == RegActivePlanes) active_count = val[5:0];
    else parallel_floor = val;
  endtask

  function automatic row_t word_row(input word_t w);
    row_t r;
    r.kind = ROW_WORD;
    r.reg_idx = RegActivePlanes;
    r.reg_val = '0;
    r.w = w;
    r.typed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t checked_row(input word_t w, input outcome_t want);
    row_t r;
    r = word_row(w);
    r.typed = 1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [0:0] idx, input logic [31:0] val);
    row_t r;
    r = word_row('0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic int rand_normal();
    return int'($urandom_range(0, 2 * One)) - One;
  endfunction

  // Receiver: random stalls, or one long hold-off on request so that the block backs up.
  always @(posedge clk) begin
    int hold_left;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every result word taken is checked field by field against the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b dist=%0d plane=%0d",
                 $time, hit, hit_distance, hit_plane);
        errors++;
      end else begin
        exp_r = pending_outcomes.pop_front();
        if (hit !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
          errors++;
        end
        if (hit_distance !== exp_r.distance) begin
          $display("%0t: hit_distance expected %0d actual %0d", $time, exp_r.distance,
                   hit_distance);
          errors++;
        end
        if (hit_plane !== exp_r.plane) begin
          $display("%0t: hit_plane expected %0d actual %0d", $time, exp_r.plane, hit_plane);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side means the block has hung.
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("tb_ray_convex_polyhedron_hit_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    int send_pcts [4] = '{0, 57, 0, 38};
    int recv_pcts [4] = '{0, 0, 57, 38};
    int phase_active [12] = '{6, 32, 4, 1, 8, 6, 63, 3, 6, 12, 33, 0};
    logic [31:0] phase_floor [12] = '{32'd4295, 32'd4295, 32'd0, 32'd4295, 32'hFFFF_FFFF,
                                       32'd4295, 32'd123456, 32'd4295, 32'd1, 32'd4295,
                                       32'd4295, 32'h0001_0000};
    int n_build, n_items, axis, reach, shift, sx, sy, sz;
    int nrm [3];
    word_t w;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The cube below spans -1..1 on every axis:
    // entries 0/1 are +x/-x, 2/3 are +y/-y, 4/5 are +z/-z.
    // With no active planes there can be no entry plane, so the cast misses.
    rows.push_back(checked_row(ray_word(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0), '0));
    rows.push_back(word_row(plane_word(0,  One, 0, 0, One)));
    rows.push_back(word_row(plane_word(1, -One, 0, 0, One)));
    rows.push_back(word_row(plane_word(2, 0,  One, 0, One)));
    rows.push_back(word_row(plane_word(3, 0, -One, 0, One)));
    rows.push_back(word_row(plane_word(4, 0, 0,  One, One)));
    rows.push_back(word_row(plane_word(5, 0, 0, -One, One)));
    rows.push_back(word_row(plane_word(31, -One, One, 0, 32'sh7FFF_FFFF)));
    rows.push_back(cfg_row(RegActivePlanes, 32'd6));
    // Straight along x from -3: enters the -x face at distance 2.
    rows.push_back(checked_row(ray_word(-3 * One, 0, 0, One, 0, 0),
                               '{1'b1, 32'sh0002_0000, 5'd1}));
    // Parallel to the +y face and outside it.
    rows.push_back(checked_row(ray_word(0, 5 * One, 0, One, 0, 0), '0));
    // A tiny heading drives the quotient into saturation.
    rows.push_back(checked_row(ray_word(-3 * One, 0, 0, 1, 0, 0),
                               '{1'b1, 32'sh7FFF_FFFF, 5'd1}));
    // Starting inside the solid gives a negative entry distance.
    rows.push_back(word_row(ray_word(0, 0, 0, One, 0, 0)));
    // Diagonal into an edge: -x and -y tie at 2, and the lower index wins.
    rows.push_back(checked_row(ray_word(-3 * One, -3 * One, 0, One, One, 0),
                               '{1'b1, 32'sh0002_0000, 5'd1}));
    // Zero heading from the centre: every plane is parallel and passed, so no entry.
    rows.push_back(checked_row(ray_word(0, 0, 0, 0, 0, 0), '0));
    // Pointing away: the solid lies behind the start.
    rows.push_back(checked_row(ray_word(-3 * One, 0, 0, -One, 0, 0), '0));
    rows.push_back(cfg_row(RegParallelLimit, 32'd0));
    // Zero facing stays parallel even with a zero limit.
    rows.push_back(checked_row(ray_word(0, 5 * One, 0, 0, 0, 0), '0));
    rows.push_back(cfg_row(RegParallelLimit, 32'hFFFF_FFFF));
    rows.push_back(checked_row(ray_word(-3 * One, 0, 0, One, 0, 0),
                               '{1'b1, 32'sh0002_0000, 5'd1}));
    // Half a unit heading falls under the top limit and counts as parallel.
    rows.push_back(word_row(ray_word(-3 * One, 0, 0, One / 2, 0, 0)));
    rows.push_back(cfg_row(RegParallelLimit, ParallelLimitReset));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_word(rows[i].w, rows[i].typed, rows[i].want);
    end

    // Random part: each phase sets the registers, rebuilds a solid in the active entries (bounded
    // once six or more are active), then casts mostly aimed rays, with some wholly random words mixed in.
    for (int p = 0; p < 12; p++) begin
      write_reg(RegActivePlanes, phase_active[p]);
      write_reg(RegParallelLimit, phase_floor[p]);
      send_idle_pct = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      n_build = (phase_active[p] > TablePlanes) ? TablePlanes : phase_active[p];
      for (int e = 0; e < n_build; e++) begin
        if (e < 6) begin
          axis = e / 2;
          nrm = '{0, 0, 0};
          nrm[axis] = (e % 2) ? -One : One;
          w = plane_word(e, nrm[0], nrm[1], nrm[2], $urandom_range(One, 8 * One));
        end else begin
          w = plane_word(e, rand_normal(), rand_normal(), rand_normal(),
                         $urandom_range(8 * One, 16 * One));
        end
        send_word(w, 0, '0);
      end
      // Early on, the receiver holds off for a long stretch while words keep coming.
      if (p == 0) hold_req = HoldOffCycles;
      n_items = (phase_active[p] > 16) ? 25 : 55;
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            w = plane_word($urandom_range(0, 31), rand_normal(), rand_normal(), rand_normal(),
                           $urandom());
          end
          1, 2: begin
            w = ray_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom());
          end
          default: begin
            reach = $urandom_range(1, 16) * One;
            shift = $urandom_range(0, 3);
            sx = int'($urandom_range(0, 2 * reach)) - reach;
            sy = int'($urandom_range(0, 2 * reach)) - reach;
            sz = int'($urandom_range(0, 2 * reach)) - reach;
            w = ray_word(sx, sy, sz,
                         (-sx + int'($urandom_range(0, One)) - One / 2) >>> shift,
                         (-sy + int'($urandom_range(0, One)) - One / 2) >>> shift,
                         (-sz + int'($urandom_range(0, One)) - One / 2) >>> shift);
          end
        endcase
        send_word(w, 0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("tb_ray_convex_polyhedron_hit_core: PASS");
    end else begin
      $display("tb_ray_convex_polyhedron_hit_core: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
